// File: rtl/arsu_pkg.sv
`timescale 1ns / 1ps

package arsu_pkg;

  localparam int PIX_W  = 16;
  localparam int CODE_W = 8;
  // scaled offset (pixel - low) * 255 needs pixel width plus code width
  localparam int NUM_W  = PIX_W + CODE_W;
  localparam int STEPS  = CODE_W;
  localparam int CNT_W  = $clog2(STEPS);

  localparam logic [CODE_W-1:0] CODE_MIN = '0;
  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  localparam logic OP_RANGE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef struct packed {
    logic range_wr;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

endpackage

// File: rtl/arsu_channels.sv
`timescale 1ns / 1ps

interface arsu_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [arsu_pkg::PIX_W-1:0] pixel;
  logic                       first_pixel;

  modport source (output valid, output opcode, output pixel, output first_pixel,
                  input ready);
  modport sink (input valid, input opcode, input pixel, input first_pixel,
                output ready);
endinterface

interface arsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [arsu_pkg::CODE_W-1:0] code;
  logic                        clamped;

  modport source (output valid, output code, output clamped, input ready);
  modport sink (input valid, input code, input clamped, output ready);
endinterface

// File: rtl/arsu_datapath.sv
`timescale 1ns / 1ps

module arsu_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  arsu_pkg::cmd_t              cmd,
  input  logic [arsu_pkg::PIX_W-1:0]  pixel,
  input  logic                        first_pixel,
  output logic [arsu_pkg::CODE_W-1:0] code,
  output logic                        clamped
);

  logic [arsu_pkg::PIX_W-1:0]  range_low_r, range_low_nxt;
  logic [arsu_pkg::PIX_W-1:0]  range_high_r, range_high_nxt;
  logic [arsu_pkg::NUM_W-1:0]  rem_r, rem_nxt;
  logic [arsu_pkg::NUM_W-1:0]  div_r, div_nxt;
  logic [arsu_pkg::CODE_W-1:0] quo_r, quo_nxt;
  logic                        below_r, above_r, empty_r;
  logic [arsu_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                        clamped_r, clamped_nxt;

  logic [arsu_pkg::PIX_W-1:0]  offset;
  logic [arsu_pkg::PIX_W-1:0]  span;
  logic                        fits;

  assign offset = pixel - range_low_r;
  assign span   = range_high_r - range_low_r;
  assign fits   = (rem_r >= div_r);

  always_comb begin
    range_low_nxt  = range_low_r;
    range_high_nxt = range_high_r;
    if (cmd.range_wr) begin
      if (first_pixel) begin
        range_low_nxt  = pixel;
        range_high_nxt = pixel;
      end else begin
        if (pixel < range_low_r)  range_low_nxt  = pixel;
        if (pixel > range_high_r) range_high_nxt = pixel;
      end
    end
  end

  // restoring divide, one quotient bit per step, divisor walks right
  always_comb begin
    rem_nxt = rem_r;
    div_nxt = div_r;
    quo_nxt = quo_r;
    if (cmd.start) begin
      // offset * 255 as offset * 256 - offset
      rem_nxt = {offset, {arsu_pkg::CODE_W{1'b0}}}
              - {{arsu_pkg::CODE_W{1'b0}}, offset};
      div_nxt = {1'b0, span, {(arsu_pkg::CODE_W-1){1'b0}}};
      quo_nxt = '0;
    end else if (cmd.step) begin
      if (fits) rem_nxt = rem_r - div_r;
      div_nxt = div_r >> 1;
      quo_nxt = {quo_r[arsu_pkg::CODE_W-2:0], fits};
    end
  end

  always_comb begin
    code_nxt    = code_r;
    clamped_nxt = clamped_r;
    if (cmd.load_out) begin
      clamped_nxt = below_r | above_r;
      if (below_r)      code_nxt = arsu_pkg::CODE_MIN;
      else if (above_r) code_nxt = arsu_pkg::CODE_MAX;
      else if (empty_r) code_nxt = arsu_pkg::CODE_MIN;
      else              code_nxt = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
    end else begin
      range_low_r  <= range_low_nxt;
      range_high_r <= range_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    code_r    <= code_nxt;
    clamped_r <= clamped_nxt;
    if (cmd.start) begin
      below_r <= (pixel < range_low_r);
      above_r <= (pixel > range_high_r);
      empty_r <= (range_high_r == range_low_r);
    end
  end

  assign code    = code_r;
  assign clamped = clamped_r;

endmodule

// File: rtl/arsu_ctrl.sv
`timescale 1ns / 1ps

module arsu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output arsu_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_HOLD
  } state_t;

  state_t                     state_r, state_nxt;
  logic [arsu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       slot_free;

  // output register is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == arsu_pkg::OP_CONVERT) begin
            cmd.start = 1'b1;
            cnt_nxt   = arsu_pkg::CNT_W'(arsu_pkg::STEPS - 1);
            state_nxt = S_CALC;
          end else begin
            cmd.range_wr = 1'b1;
          end
        end
      end
      S_CALC: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/auto_range_16_to_8_stretch_unit.sv
`timescale 1ns / 1ps
// range word: no result, next word can be taken in the following cycle
// convert word: 8 divide steps, then the result is loaded into the output register
// once that register is free; no new word is taken until the result is loaded
// the 8 steps are the restoring divider, one quotient bit per cycle
// synchronous active-low reset clears the held range to [0, 0] and empties the output

module auto_range_16_to_8_stretch_unit (
  input  logic        clk,
  input  logic        rst_n,
  arsu_in_if.sink     in_ch,
  arsu_out_if.source  out_ch
);

  arsu_pkg::cmd_t cmd;

  arsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  arsu_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .pixel       (in_ch.pixel),
    .first_pixel (in_ch.first_pixel),
    .code        (out_ch.code),
    .clamped     (out_ch.clamped)
  );

  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == arsu_pkg::OP_CONVERT))
      |=> !in_ch.ready)
    else $error("input taken while divide in progress");

  a_range_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == arsu_pkg::OP_RANGE))
      |=> in_ch.ready)
    else $error("range word did not complete in one cycle");

  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clamped)
      |-> (out_ch.code == arsu_pkg::CODE_MIN || out_ch.code == arsu_pkg::CODE_MAX))
    else $error("saturated word with code off the rails");

endmodule
